FILE: hdl/lpc_signal_restore_core_assert.svh
// assertion macros for the checker file of the lpc signal restore core
// depends on nothing; include by bare file name
`ifndef LPC_SIGNAL_RESTORE_CORE_ASSERT_SVH
`define LPC_SIGNAL_RESTORE_CORE_ASSERT_SVH

// condition holds in the same cycle
`define LPCSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpcsr assertion failed");

// condition holds in the next cycle
`define LPCSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpcsr assertion failed");

`endif

FILE: hdl/lpcsr_pkg.sv
// shared widths, command codes and control structs of the lpc signal restore core
// no dependencies
package lpcsr_pkg;

    localparam int DATA_W      = 32;
    localparam int TAP_W       = 16;
    localparam int ACC_W       = DATA_W + TAP_W;
    localparam int CMD_W       = 2;
    localparam int ORDER_W     = 6;
    localparam int SHIFT_W     = 4;
    localparam int LEN_W       = 16;
    localparam int MAX_ORDER_DEF = 32;

    localparam logic [CMD_W-1:0] CMD_BEGIN  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COEF   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

    // controls for every cell of the ring
    typedef struct packed {
        logic rotate;
        logic push;
    } t_cell_ctl;

    // controls for the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic term;
    } t_mac_ctl;

endpackage

FILE: hdl/lpcsr_cell.sv
// one ring cell: holds one history word and one tap
// depends on lpcsr_pkg
module lpcsr_cell (
    input  logic                             i_clk,
    input  lpcsr_pkg::t_cell_ctl             i_ctl,
    input  logic                             i_tap_load,
    input  logic [lpcsr_pkg::TAP_W-1:0]      i_tap_val,
    input  logic [lpcsr_pkg::DATA_W-1:0]     i_hist_shift,
    input  logic [lpcsr_pkg::DATA_W-1:0]     i_hist_rot,
    input  logic [lpcsr_pkg::TAP_W-1:0]      i_tap_rot,
    output logic [lpcsr_pkg::DATA_W-1:0]     o_hist,
    output logic [lpcsr_pkg::TAP_W-1:0]      o_tap
);

    logic [lpcsr_pkg::DATA_W-1:0] r_hist;
    logic [lpcsr_pkg::TAP_W-1:0]  r_tap;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_hist <= i_hist_shift;
        end else if (i_ctl.rotate) begin
            r_hist <= i_hist_rot;
        end
        if (i_ctl.rotate) begin
            r_tap <= i_tap_rot;
        end else if (i_tap_load) begin
            r_tap <= i_tap_val;
        end
    end

    assign o_hist = r_hist;
    assign o_tap  = r_tap;

endmodule

FILE: hdl/lpcsr_mac.sv
// shared multiply-accumulate unit with final shift and residual add
// depends on lpcsr_pkg
module lpcsr_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lpcsr_pkg::t_mac_ctl               i_ctl,
    input  logic [lpcsr_pkg::DATA_W-1:0]      i_hist,
    input  logic [lpcsr_pkg::TAP_W-1:0]       i_tap,
    input  logic [lpcsr_pkg::SHIFT_W-1:0]     i_shift,
    input  logic [lpcsr_pkg::DATA_W-1:0]      i_value,
    output logic [lpcsr_pkg::DATA_W-1:0]      o_result
);

    logic signed [lpcsr_pkg::ACC_W-1:0] r_prod;
    logic                               r_prod_vld;
    logic signed [lpcsr_pkg::ACC_W-1:0] r_acc;
    logic signed [lpcsr_pkg::ACC_W-1:0] shifted;

    // product registered before the accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.term;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_hist) * $signed(i_tap);
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + r_prod;
        end
    end

    // low bits of a wrapped sum only depend on low bits of the terms
    assign shifted  = r_acc >>> i_shift;
    assign o_result = shifted[lpcsr_pkg::DATA_W-1:0] + i_value;

endmodule

FILE: hdl/lpc_signal_restore_core.sv
// top level of the lpc signal restore core: command decode, sequencer, cell ring
// depends on lpcsr_pkg, lpcsr_cell, lpcsr_mac
//
// Rebuilds one linear-prediction audio subframe. A begin transaction latches
// order (clamped to MAX_ORDER), shift and block size and clears the counters;
// coefficient transactions load taps in order, extra ones are dropped. Sample
// transactions give one result each while the block is not full: warm-up
// samples pass through, later ones are residual plus the shifted prediction,
// wrapped to 32 bits. Taps and history sit in a ring of MAX_ORDER cells; the
// ring turns once per predicted sample and the cell at its head feeds a single
// 32x16 multiplier. Begin and coefficient transactions leave the input
// unstalled; a warm-up sample goes from accept straight to emit, a predicted
// sample through accept, one full turn of the ring, accumulate drain and
// emit. Results sit in an output register so the next transaction can be
// taken while one waits. History is not cleared on begin; entries never
// written since reset are undefined.
module lpc_signal_restore_core #(
    parameter int MAX_ORDER = lpcsr_pkg::MAX_ORDER_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [lpcsr_pkg::CMD_W-1:0]       i_command,
    input  logic signed [lpcsr_pkg::DATA_W-1:0] i_value,
    input  logic [lpcsr_pkg::ORDER_W-1:0]     i_order,
    input  logic [lpcsr_pkg::SHIFT_W-1:0]     i_shift,
    input  logic [lpcsr_pkg::LEN_W-1:0]       i_block_size,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [lpcsr_pkg::DATA_W-1:0] o_sample,
    output logic                              o_last_in_block
);

    localparam int STEP_W = $clog2(MAX_ORDER + 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]                         r_state, n_state;
    logic [STEP_W-1:0]                  r_step;
    logic [lpcsr_pkg::ORDER_W-1:0]      r_order;
    logic [lpcsr_pkg::SHIFT_W-1:0]      r_shift;
    logic [lpcsr_pkg::LEN_W-1:0]        r_block_len;
    logic [lpcsr_pkg::LEN_W-1:0]        r_sample_count;
    logic [lpcsr_pkg::ORDER_W-1:0]      r_tap_count;
    logic [lpcsr_pkg::DATA_W-1:0]       r_value;
    logic                               r_last_pend;
    logic                               r_out_valid;
    logic [lpcsr_pkg::DATA_W-1:0]       r_sample;
    logic                               r_last;

    logic                               in_fire;
    logic                               is_begin;
    logic                               is_coef;
    logic                               is_sample;
    logic                               in_block;
    logic                               warm_up;
    logic                               tap_ok;
    logic                               emit_fire;
    logic [lpcsr_pkg::ORDER_W-1:0]      n_terms;
    logic [lpcsr_pkg::ORDER_W-1:0]      order_clamped;
    logic [lpcsr_pkg::DATA_W-1:0]       mac_result;

    lpcsr_pkg::t_cell_ctl               cell_ctl;
    lpcsr_pkg::t_mac_ctl                mac_ctl;

    logic [lpcsr_pkg::DATA_W-1:0]       hist [MAX_ORDER];
    logic [lpcsr_pkg::TAP_W-1:0]        taps [MAX_ORDER];

    // input handshake and decode
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_fire    = i_in_valid && !o_in_stall;
    assign is_begin   = in_fire && (i_command == lpcsr_pkg::CMD_BEGIN);
    assign is_coef    = in_fire && (i_command == lpcsr_pkg::CMD_COEF);
    assign is_sample  = in_fire && (i_command == lpcsr_pkg::CMD_SAMPLE);
    assign in_block   = (r_sample_count < r_block_len);
    assign warm_up    = (r_sample_count < lpcsr_pkg::LEN_W'(r_order));
    assign tap_ok     = (r_tap_count < r_order);

    assign order_clamped = (i_order > lpcsr_pkg::ORDER_W'(MAX_ORDER)) ?
                           lpcsr_pkg::ORDER_W'(MAX_ORDER) : i_order;

    // taps not yet loaded do not take part in the sum
    assign n_terms = (r_tap_count < r_order) ? r_tap_count : r_order;

    // result leaves when the output register is free or being emptied
    assign emit_fire = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (is_sample && in_block) begin
                    // warm-up skips the ring turn: zero sum plus value
                    n_state = warm_up ? ST_EMIT : ST_MAC;
                end
            end
            ST_MAC: begin
                if (r_step == STEP_W'(MAX_ORDER - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_EMIT;
            ST_EMIT: begin
                if (emit_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_step         <= '0;
            r_order        <= lpcsr_pkg::ORDER_W'(1);
            r_shift        <= '0;
            r_block_len    <= lpcsr_pkg::LEN_W'(1);
            r_sample_count <= '0;
            r_tap_count    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_MAC) begin
                r_step <= r_step + STEP_W'(1);
            end else begin
                r_step <= '0;
            end
            if (is_begin) begin
                r_order        <= order_clamped;
                r_shift        <= i_shift;
                r_block_len    <= i_block_size;
                r_sample_count <= '0;
                r_tap_count    <= '0;
            end
            if (is_coef && tap_ok) begin
                r_tap_count <= r_tap_count + lpcsr_pkg::ORDER_W'(1);
            end
            if (is_sample && in_block) begin
                r_sample_count <= r_sample_count + lpcsr_pkg::LEN_W'(1);
            end
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (is_sample && in_block) begin
            r_value     <= i_value;
            // count is below block length, so the increment cannot wrap
            r_last_pend <= ((r_sample_count + lpcsr_pkg::LEN_W'(1)) == r_block_len);
        end
        if (emit_fire) begin
            r_sample <= mac_result;
            r_last   <= r_last_pend;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sample        = r_sample;
    assign o_last_in_block = r_last;

    // ring control: one full turn per predicted sample, push on emit
    assign cell_ctl.rotate = (r_state == ST_MAC);
    assign cell_ctl.push   = emit_fire;

    // head cell holds tap index r_step during the turn
    assign mac_ctl.clear = is_sample;
    assign mac_ctl.term  = (r_state == ST_MAC) &&
                           (lpcsr_pkg::ORDER_W'(r_step) < n_terms);

    genvar k;
    generate
        for (k = 0; k < MAX_ORDER; k++) begin : g_cell
            logic [lpcsr_pkg::DATA_W-1:0] hist_shift;
            if (k == 0) begin : g_head
                assign hist_shift = mac_result;
            end else begin : g_body
                assign hist_shift = hist[k-1];
            end

            lpcsr_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (cell_ctl),
                .i_tap_load   (is_coef && tap_ok &&
                               (r_tap_count == lpcsr_pkg::ORDER_W'(k))),
                .i_tap_val    (i_value[lpcsr_pkg::TAP_W-1:0]),
                .i_hist_shift (hist_shift),
                .i_hist_rot   (hist[(k + 1) % MAX_ORDER]),
                .i_tap_rot    (taps[(k + 1) % MAX_ORDER]),
                .o_hist       (hist[k]),
                .o_tap        (taps[k])
            );
        end
    endgenerate

    lpcsr_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_hist   (hist[0]),
        .i_tap    (taps[0]),
        .i_shift  (r_shift),
        .i_value  (r_value),
        .o_result (mac_result)
    );

endmodule

FILE: hdl/lpcsr_checker.sv
// port-level checker for lpc_signal_restore_core, attached by bind
// depends on lpcsr_pkg and lpc_signal_restore_core_assert.svh
`include "lpc_signal_restore_core_assert.svh"

module lpcsr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic [lpcsr_pkg::CMD_W-1:0]   i_command,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [lpcsr_pkg::DATA_W-1:0]  o_sample,
    input logic                          o_last_in_block
);

    logic                          out_hold;
    logic                          cmd_done;
    logic [lpcsr_pkg::DATA_W:0]    out_word;

    assign out_hold = o_out_valid && i_out_stall;
    assign cmd_done = i_in_valid && !o_in_stall && (i_command != lpcsr_pkg::CMD_SAMPLE);
    assign out_word = {o_last_in_block, o_sample};

    // stalled result transaction holds
    `LPCSR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_hold, o_out_valid && $stable(out_word))

    // non-sample transactions leave the input unstalled in the next cycle
    `LPCSR_ASSERT_NEXT(a_cmd_one_cycle, i_clk, i_rst_n, cmd_done, !o_in_stall)

    // a new result only comes out of a busy sequencer
    `LPCSR_ASSERT_NOW(a_out_from_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

    // a result is loaded only when the sequencer goes back to idle
    `LPCSR_ASSERT_NOW(a_out_then_idle, i_clk, i_rst_n, $rose(o_out_valid), !o_in_stall)

endmodule

bind lpc_signal_restore_core lpcsr_checker u_lpcsr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_command       (i_command),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_sample        (o_sample),
    .o_last_in_block (o_last_in_block)
);
